// File: src/mcc2d_pkg.sv
// shared types and constants for the replicate-pad convolution layer
package mcc2d_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_FEAT = 2'd0,
    CMD_LOAD_WGT  = 2'd1,
    CMD_LOAD_BIAS = 2'd2,
    CMD_COMPUTE   = 2'd3
  } cmd_t;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_SAT = 2'd1;
  localparam logic [1:0] STATUS_IDX = 2'd2;

  // wide enough for the exact sum at the largest channel count and kernel
  localparam int ACC_W = 48;

  typedef struct packed {
    logic [1:0]         command;
    logic [5:0]         in_channel;
    logic [5:0]         out_channel;
    logic [7:0]         row;
    logic [7:0]         col;
    logic [3:0]         tap_row;
    logic [3:0]         tap_col;
    logic signed [15:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic [5:0]         out_channel_id;
    logic [7:0]         out_row;
    logic [7:0]         out_col;
    logic [1:0]         status;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic clear;     // zero accumulator, latch pixel
    logic issue;     // present a read at the current tap
    logic step;      // advance tap / channel counters
    logic mac;       // accumulate last product
    logic add_bias;  // fold bias into sum
    logic finish;    // build result word
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_tap;
  } dp_sts_t;

endpackage

// File: src/mcc2d_ram.sv
// generic RAM with one write port and one registered read port
module mcc2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/mcc2d_ctrl.sv
// controller state machine for one compute command
module mcc2d_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                out_taken,
  input  mcc2d_pkg::dp_sts_t  sts,
  output mcc2d_pkg::dp_cmd_t  cmd,
  output logic                busy,
  output logic                out_valid
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RUN  = 7'b0000010,
    S_DR1  = 7'b0000100,
    S_DR2  = 7'b0001000,
    S_BIAS = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  // products arrive in a pipeline behind the issues
  logic issue_d1_r, issue_d2_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.clear = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        // read issued this cycle; data passes the RAM output and the product register before it is accumulated
        cmd.issue = 1'b1;
        cmd.step = 1'b1;
        if (sts.last_tap) begin
          state_nxt = S_DR1;
        end
      end
      S_DR1: state_nxt = S_DR2;
      S_DR2: state_nxt = S_BIAS;
      S_BIAS: begin
        cmd.add_bias = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_taken) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.mac = issue_d2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      issue_d1_r <= 1'b0;
      issue_d2_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      issue_d1_r <= cmd.issue;
      issue_d2_r <= issue_d1_r;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
endmodule

// File: src/mcc2d_dp.sv
// datapath: stores, tap walk, multiply-accumulate and result packing
module mcc2d_dp #(
  parameter int IN_CHANNELS  = 32,
  parameter int OUT_CHANNELS = 1,
  parameter int HEIGHT       = 32,
  parameter int WIDTH        = 32,
  parameter int KERNEL       = 5,
  parameter int FRAC_BITS    = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_en,
  input  mcc2d_pkg::in_word_t   in_word,
  input  mcc2d_pkg::dp_cmd_t    cmd,
  output mcc2d_pkg::dp_sts_t    sts,
  output mcc2d_pkg::out_word_t  res
);
  localparam int CW   = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
  localparam int HW   = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
  localparam int WW   = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int KW   = (KERNEL > 1) ? $clog2(KERNEL) : 1;
  localparam int PAD  = (KERNEL - 1) / 2;
  localparam int FD   = IN_CHANNELS * HEIGHT * WIDTH;
  localparam int WD   = OUT_CHANNELS * IN_CHANNELS * KERNEL * KERNEL;
  localparam int FA   = (FD > 1) ? $clog2(FD) : 1;
  localparam int WA   = (WD > 1) ? $clog2(WD) : 1;
  localparam int BA   = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
  localparam int ACC  = mcc2d_pkg::ACC_W;

  // load index checks and addresses
  logic f_ok, w_ok, b_ok, c_ok;
  assign f_ok = (32'(in_word.in_channel) < IN_CHANNELS) && (32'(in_word.row) < HEIGHT)
             && (32'(in_word.col) < WIDTH);
  assign w_ok = (32'(in_word.out_channel) < OUT_CHANNELS)
             && (32'(in_word.in_channel) < IN_CHANNELS)
             && (32'(in_word.tap_row) < KERNEL) && (32'(in_word.tap_col) < KERNEL);
  assign b_ok = (32'(in_word.out_channel) < OUT_CHANNELS);

  logic [FA-1:0] f_waddr;
  logic [WA-1:0] w_waddr;
  assign f_waddr = FA'((32'(in_word.in_channel) * HEIGHT + 32'(in_word.row)) * WIDTH
                       + 32'(in_word.col));
  assign w_waddr = WA'(((32'(in_word.out_channel) * IN_CHANNELS + 32'(in_word.in_channel))
                        * KERNEL + 32'(in_word.tap_row)) * KERNEL + 32'(in_word.tap_col));

  // pixel under compute
  logic [5:0] oc_r;
  logic [7:0] row_r, col_r;
  logic       bad_r;
  assign c_ok = b_ok && (32'(in_word.row) < HEIGHT) && (32'(in_word.col) < WIDTH);

  // tap walk: channel innermost; running base addresses avoid multipliers
  logic [CW-1:0] ch_r;
  logic [KW-1:0] kr_r, kc_r;
  logic [FA-1:0] plane_r;   // ch * HEIGHT * WIDTH
  logic [WA-1:0] wa_r;      // current weight address
  logic [WA-1:0] wrow_r;    // weight address of channel 0 at this tap
  logic [HW-1:0] sr;
  logic [WW-1:0] sc;
  logic signed [9:0] sr_raw, sc_raw;
  logic [FA-1:0] f_raddr;
  logic last_ch, last_kc, last_kr;

  assign sr_raw = $signed({2'b00, row_r}) + $signed({1'b0, 9'(kr_r)}) - 10'(PAD);
  assign sc_raw = $signed({2'b00, col_r}) + $signed({1'b0, 9'(kc_r)}) - 10'(PAD);
  assign sr = (sr_raw < 0) ? '0 : (sr_raw > 10'(HEIGHT - 1)) ? HW'(HEIGHT - 1) : HW'(sr_raw);
  assign sc = (sc_raw < 0) ? '0 : (sc_raw > 10'(WIDTH - 1)) ? WW'(WIDTH - 1) : WW'(sc_raw);
  assign f_raddr = plane_r + FA'(32'(sr) * WIDTH) + FA'(sc);

  assign last_ch = (32'(ch_r) == IN_CHANNELS - 1);
  assign last_kc = (32'(kc_r) == KERNEL - 1);
  assign last_kr = (32'(kr_r) == KERNEL - 1);
  assign sts.last_tap = last_ch && last_kc && last_kr;

  logic [WA-1:0] w_base;
  assign w_base = WA'(32'(in_word.out_channel) * IN_CHANNELS * KERNEL * KERNEL);

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      oc_r    <= in_word.out_channel;
      row_r   <= in_word.row;
      col_r   <= in_word.col;
      bad_r   <= !c_ok;
      ch_r    <= '0;
      kr_r    <= '0;
      kc_r    <= '0;
      plane_r <= '0;
      wa_r    <= w_base;
      wrow_r  <= w_base;
    end else if (cmd.step) begin
      if (last_ch) begin
        ch_r    <= '0;
        plane_r <= '0;
        wa_r    <= wrow_r + WA'(1);
        wrow_r  <= wrow_r + WA'(1);
        if (last_kc) begin
          kc_r <= '0;
          kr_r <= last_kr ? '0 : kr_r + KW'(1);
        end else begin
          kc_r <= kc_r + KW'(1);
        end
      end else begin
        ch_r    <= ch_r + CW'(1);
        plane_r <= plane_r + FA'(HEIGHT * WIDTH);
        wa_r    <= wa_r + WA'(KERNEL * KERNEL);
      end
    end
  end

  logic [15:0] f_q, w_q, b_q;
  mcc2d_ram #(.WIDTH(16), .DEPTH(FD)) u_feat (
    .clk(clk), .we(load_en && in_word.command == mcc2d_pkg::CMD_LOAD_FEAT && f_ok),
    .waddr(f_waddr), .wdata(in_word.value), .raddr(f_raddr), .rdata(f_q));
  mcc2d_ram #(.WIDTH(16), .DEPTH(WD)) u_wgt (
    .clk(clk), .we(load_en && in_word.command == mcc2d_pkg::CMD_LOAD_WGT && w_ok),
    .waddr(w_waddr), .wdata(in_word.value), .raddr(wa_r), .rdata(w_q));
  mcc2d_ram #(.WIDTH(16), .DEPTH(OUT_CHANNELS)) u_bias (
    .clk(clk), .we(load_en && in_word.command == mcc2d_pkg::CMD_LOAD_BIAS && b_ok),
    .waddr(BA'(in_word.out_channel)), .wdata(in_word.value), .raddr(BA'(oc_r)),
    .rdata(b_q));

  // product register then accumulate
  logic signed [31:0] prod_r;
  logic signed [ACC-1:0] acc_r;
  always_ff @(posedge clk) begin
    prod_r <= $signed(w_q) * $signed(f_q);
    if (!rst_n || cmd.clear) begin
      acc_r <= '0;
    end else if (cmd.mac) begin
      acc_r <= acc_r + ACC'(prod_r);
    end else if (cmd.add_bias) begin
      acc_r <= acc_r + (ACC'($signed(b_q)) <<< FRAC_BITS);
    end
  end

  // floor shift and saturate
  logic signed [ACC-1:0] shifted;
  assign shifted = acc_r >>> FRAC_BITS;
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res.out_channel_id <= oc_r;
      res.out_row        <= row_r;
      res.out_col        <= col_r;
      if (bad_r) begin
        res.out_value <= '0;
        res.status    <= mcc2d_pkg::STATUS_IDX;
      end else if (shifted > ACC'(32767)) begin
        res.out_value <= 16'sh7fff;
        res.status    <= mcc2d_pkg::STATUS_SAT;
      end else if (shifted < -ACC'(32768)) begin
        res.out_value <= -16'sh8000;
        res.status    <= mcc2d_pkg::STATUS_SAT;
      end else begin
        res.out_value <= shifted[15:0];
        res.status    <= mcc2d_pkg::STATUS_OK;
      end
    end
  end
endmodule

// File: src/multichannel_conv2d_replicate_pad.sv
// top level of the multichannel replicate-pad convolution layer
//  channel  direction  payload      handshake
//  in_      input      in_word_t    in_valid / in_ready
//  out_     output     out_word_t   out_valid / out_ready
// loads do not stall the input; a compute walks all taps on the single shared
// multiply-accumulate.
// a bad-index compute still walks the taps and reports status 2.
// reset is synchronous active low; memories need no clearing pass.
// a result waits in the output register until taken; no new word enters meanwhile.
module multichannel_conv2d_replicate_pad #(
  parameter int IN_CHANNELS  = 32,
  parameter int OUT_CHANNELS = 1,
  parameter int HEIGHT       = 32,
  parameter int WIDTH        = 32,
  parameter int KERNEL       = 5,
  parameter int FRAC_BITS    = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mcc2d_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mcc2d_pkg::out_word_t out_data
);
  mcc2d_pkg::dp_cmd_t cmd;
  mcc2d_pkg::dp_sts_t sts;
  logic busy, acc_in, start;

  assign in_ready = !busy;
  assign acc_in   = in_valid && in_ready;
  assign start    = acc_in && (in_data.command == mcc2d_pkg::CMD_COMPUTE);

  mcc2d_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .out_taken(out_ready), .sts(sts),
    .cmd(cmd), .busy(busy), .out_valid(out_valid));

  mcc2d_dp #(
    .IN_CHANNELS(IN_CHANNELS), .OUT_CHANNELS(OUT_CHANNELS), .HEIGHT(HEIGHT),
    .WIDTH(WIDTH), .KERNEL(KERNEL), .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .load_en(acc_in), .in_word(in_data), .cmd(cmd),
    .sts(sts), .res(out_data));
endmodule

// File: src/mcc2d_checker.sv
// port-level checks for the convolution layer, bound to the top level
module mcc2d_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input mcc2d_pkg::in_word_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input mcc2d_pkg::out_word_t out_data
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed");
  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command != mcc2d_pkg::CMD_COMPUTE |=> in_ready)
    else $error("load stalled the block");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= mcc2d_pkg::STATUS_IDX) else $error("bad status");
endmodule

bind multichannel_conv2d_replicate_pad mcc2d_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));

// File: tb/tb_multichannel_conv2d_replicate_pad.sv
// testbench for the replicate-pad convolution layer: table-driven and random words vs a predictor
`timescale 1ns / 1ps
module tb_multichannel_conv2d_replicate_pad;

  localparam int N_IC   = 32;
  localparam int N_OC   = 1;
  localparam int N_H    = 32;
  localparam int N_W    = 32;
  localparam int N_K    = 5;
  localparam int FRAC   = 12;
  localparam int HALF_K = (N_K - 1) / 2;
  localparam int N_RAND = 750;

  typedef struct {
    mcc2d_pkg::in_word_t  w;
    bit                   typed;
    mcc2d_pkg::out_word_t res;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  mcc2d_pkg::in_word_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  mcc2d_pkg::out_word_t out_data;

  // predictor state
  logic signed [15:0] feat_mem [N_IC*N_H*N_W];
  bit                 feat_wr  [N_IC*N_H*N_W];
  logic signed [15:0] wgt_mem  [N_OC*N_IC*N_K*N_K];
  logic signed [15:0] bias_val [N_OC];

  mcc2d_pkg::in_word_t  word_q[$];
  mcc2d_pkg::out_word_t pixel_q[$];
  row_t                 dir_rows[$];
  int                   errors = 0;

  multichannel_conv2d_replicate_pad u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  initial begin
    #10ms;
    $display("[multichannel_conv2d_replicate_pad] ERROR");
    $finish;
  end

  function automatic mcc2d_pkg::in_word_t mk(mcc2d_pkg::cmd_t cmd, int ic, int oc, int r,
                                             int c, int tr, int tc, int v);
    mcc2d_pkg::in_word_t w;
    w.command = cmd;
    w.in_channel = ic[5:0];
    w.out_channel = oc[5:0];
    w.row = r[7:0];
    w.col = c[7:0];
    w.tap_row = tr[3:0];
    w.tap_col = tc[3:0];
    w.value = v[15:0];
    return w;
  endfunction

  function automatic int clampi(int v, int lim);
    if (v < 0) return 0;
    if (v > lim - 1) return lim - 1;
    return v;
  endfunction

  // true when every feature the pixel's window touches has been written
  function automatic bit window_ready(int r, int c);
    int sr, sc;
    for (int dr = -HALF_K; dr <= HALF_K; dr++)
      for (int dc = -HALF_K; dc <= HALF_K; dc++) begin
        sr = clampi(r + dr, N_H);
        sc = clampi(c + dc, N_W);
        for (int ch = 0; ch < N_IC; ch++)
          if (!feat_wr[(ch * N_H + sr) * N_W + sc]) return 1'b0;
      end
    return 1'b1;
  endfunction

  // updates the stores and returns 1 with the pixel when a word gives a result
  function automatic bit conv_pixel(mcc2d_pkg::in_word_t w, output mcc2d_pkg::out_word_t res);
    longint acc;
    int sr, sc, ic, oc, r, c;
    ic = w.in_channel;
    oc = w.out_channel;
    r = w.row;
    c = w.col;
    res = '0;
    case (mcc2d_pkg::cmd_t'(w.command))
      mcc2d_pkg::CMD_LOAD_FEAT: begin
        if (ic < N_IC && r < N_H && c < N_W) begin
          feat_mem[(ic * N_H + r) * N_W + c] = w.value;
          feat_wr[(ic * N_H + r) * N_W + c] = 1'b1;
        end
        return 1'b0;
      end
      mcc2d_pkg::CMD_LOAD_WGT: begin
        if (oc < N_OC && ic < N_IC && w.tap_row < N_K && w.tap_col < N_K)
          wgt_mem[((oc * N_IC + ic) * N_K + w.tap_row) * N_K + w.tap_col] = w.value;
        return 1'b0;
      end
      mcc2d_pkg::CMD_LOAD_BIAS: begin
        if (oc < N_OC) bias_val[oc] = w.value;
        return 1'b0;
      end
      default: begin
        res.out_channel_id = w.out_channel;
        res.out_row = w.row;
        res.out_col = w.col;
        if (oc >= N_OC || r >= N_H || c >= N_W) begin
          res.status = mcc2d_pkg::STATUS_IDX;
          return 1'b1;
        end
        acc = 0;
        for (int kr = 0; kr < N_K; kr++)
          for (int kc = 0; kc < N_K; kc++) begin
            sr = clampi(r + kr - HALF_K, N_H);
            sc = clampi(c + kc - HALF_K, N_W);
            for (int ch = 0; ch < N_IC; ch++)
              acc += longint'(wgt_mem[((oc * N_IC + ch) * N_K + kr) * N_K + kc]) *
                     longint'(feat_mem[(ch * N_H + sr) * N_W + sc]);
          end
        acc += longint'(bias_val[oc]) * (longint'(1) << FRAC);
        acc = acc >>> FRAC;
        res.status = mcc2d_pkg::STATUS_OK;
        if (acc > 32767) begin
          acc = 32767;
          res.status = mcc2d_pkg::STATUS_SAT;
        end else if (acc < -32768) begin
          acc = -32768;
          res.status = mcc2d_pkg::STATUS_SAT;
        end
        res.out_value = acc[15:0];
        return 1'b1;
      end
    endcase
  endfunction

  task automatic queue_word(mcc2d_pkg::in_word_t w);
    mcc2d_pkg::out_word_t res;
    word_q.push_back(w);
    if (conv_pixel(w, res)) pixel_q.push_back(res);
  endtask

  task automatic add_row(mcc2d_pkg::in_word_t w, bit typed, mcc2d_pkg::out_word_t res);
    row_t rw;
    rw.w = w;
    rw.typed = typed;
    rw.res = res;
    dir_rows.push_back(rw);
  endtask

  // all weights and bias, plus two corner patches of the feature map
  task automatic fill_stores();
    for (int ic = 0; ic < N_IC; ic++)
      for (int tr = 0; tr < N_K; tr++)
        for (int tc = 0; tc < N_K; tc++)
          queue_word(mk(mcc2d_pkg::CMD_LOAD_WGT, ic, 0, 0, 0, tr, tc,
                        $urandom_range(0, 1023) - 512));
    queue_word(mk(mcc2d_pkg::CMD_LOAD_BIAS, 0, 0, 0, 0, 0, 0, $urandom_range(0, 8191) - 4096));
    for (int ch = 0; ch < N_IC; ch++)
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          queue_word(mk(mcc2d_pkg::CMD_LOAD_FEAT, ch, 0, r, c, 0, 0,
                        $urandom_range(0, 8191) - 4096));
    for (int ch = 0; ch < N_IC; ch++)
      for (int r = N_H - 3; r < N_H; r++)
        for (int c = N_W - 3; c < N_W; c++)
          queue_word(mk(mcc2d_pkg::CMD_LOAD_FEAT, ch, 0, r, c, 0, 0,
                        $urandom_range(0, 65535)));
  endtask

  task automatic pick_pixel(output int r, output int c);
    for (int t = 0; t < 20; t++) begin
      if ($urandom_range(0, 4) == 0) begin
        r = $urandom_range(N_H - 8, N_H - 1);
        c = $urandom_range(N_W - 8, N_W - 1);
      end else begin
        r = $urandom_range(0, 7);
        c = $urandom_range(0, 7);
      end
      if (window_ready(r, c)) return;
    end
    r = 0;
    c = 0;
  endtask

  task automatic rand_word();
    mcc2d_pkg::in_word_t w;
    int sel, r, c;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      if ($urandom_range(0, 3) == 0)
        w = mk(mcc2d_pkg::CMD_LOAD_FEAT, $urandom_range(0, N_IC - 1), 0,
               $urandom_range(N_H - 8, N_H - 1), $urandom_range(N_W - 8, N_W - 1), 0, 0,
               $urandom_range(0, 65535));
      else
        w = mk(mcc2d_pkg::CMD_LOAD_FEAT, $urandom_range(0, N_IC - 1), 0, $urandom_range(0, 7),
               $urandom_range(0, 7), 0, 0, $urandom_range(0, 8191) - 4096);
    end else if (sel < 60) begin
      w = mk(mcc2d_pkg::CMD_LOAD_WGT, $urandom_range(0, N_IC - 1), 0, 0, 0,
             $urandom_range(0, N_K - 1), $urandom_range(0, N_K - 1),
             ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1023) - 512);
    end else if (sel < 65) begin
      w = mk(mcc2d_pkg::CMD_LOAD_BIAS, 0, 0, 0, 0, 0, 0, $urandom_range(0, 65535));
    end else if (sel < 75) begin
      pick_pixel(r, c);
      w = mk(mcc2d_pkg::CMD_COMPUTE, $urandom_range(0, 63), 0, r, c, $urandom_range(0, 15),
             $urandom_range(0, 15), $urandom_range(0, 65535));
    end else if (sel < 80) begin
      w = mk(mcc2d_pkg::CMD_COMPUTE, 0, $urandom_range(0, 63), $urandom_range(N_H, 255),
             $urandom_range(0, 255), 0, 0, 0);
    end else begin
      w = mcc2d_pkg::in_word_t'(54'({$urandom, $urandom}));
      // a full-range compute that lands in range must not touch unwritten features
      if (w.command == mcc2d_pkg::CMD_COMPUTE && w.out_channel < N_OC && w.row < N_H &&
          w.col < N_W && !window_ready(w.row, w.col))
        w.row = 8'($urandom_range(N_H, 255));
    end
    queue_word(w);
  endtask

  task automatic note(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // result checker
  always @(posedge clk) begin
    mcc2d_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        note("unexpected word", 0, 0);
      end else begin
        want = pixel_q.pop_front();
        if (out_data.out_value !== want.out_value)
          note("out_value", out_data.out_value, want.out_value);
        if (out_data.out_channel_id !== want.out_channel_id)
          note("out_channel_id", out_data.out_channel_id, want.out_channel_id);
        if (out_data.out_row !== want.out_row) note("out_row", out_data.out_row, want.out_row);
        if (out_data.out_col !== want.out_col) note("out_col", out_data.out_col, want.out_col);
        if (out_data.status !== want.status) note("status", out_data.status, want.status);
      end
    end
  end

  // receiver stalls; one long hold-off lets the block back up onto its input
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 20000 && cyc < 23000) out_ready <= 1'b0;
      else if (cyc >= 40000 && cyc < 60000) out_ready <= 1'b1;
      else out_ready <= (cyc % 64 < 40) ? 1'b1 : ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    mcc2d_pkg::out_word_t idx_err, none;
    int fill_at, burst, gap, waited;
    idx_err = '0;
    none = '0;
    idx_err.status = mcc2d_pkg::STATUS_IDX;

    // bad-index computes need no loaded data
    idx_err.out_channel_id = 6'd63;
    add_row(mk(mcc2d_pkg::CMD_COMPUTE, 0, 63, 0, 0, 0, 0, 0), 1'b1, idx_err);
    idx_err.out_channel_id = 6'd0;
    idx_err.out_row = 8'd255;
    idx_err.out_col = 8'd255;
    add_row(mk(mcc2d_pkg::CMD_COMPUTE, 63, 0, 255, 255, 15, 15, -1), 1'b1, idx_err);
    idx_err.out_row = 8'd32;
    idx_err.out_col = 8'd0;
    add_row(mk(mcc2d_pkg::CMD_COMPUTE, 0, 0, 32, 0, 0, 0, 0), 1'b1, idx_err);
    idx_err.out_row = 8'd0;
    idx_err.out_col = 8'd32;
    add_row(mk(mcc2d_pkg::CMD_COMPUTE, 0, 0, 0, 32, 0, 0, 0), 1'b1, idx_err);
    // bad-index loads are dropped
    add_row(mk(mcc2d_pkg::CMD_LOAD_FEAT, 32, 0, 0, 0, 0, 0, 32767), 1'b0, none);
    add_row(mk(mcc2d_pkg::CMD_LOAD_FEAT, 0, 0, 32, 0, 0, 0, 32767), 1'b0, none);
    add_row(mk(mcc2d_pkg::CMD_LOAD_FEAT, 0, 0, 0, 255, 0, 0, 32767), 1'b0, none);
    add_row(mk(mcc2d_pkg::CMD_LOAD_WGT, 0, 1, 0, 0, 0, 0, 32767), 1'b0, none);
    add_row(mk(mcc2d_pkg::CMD_LOAD_WGT, 0, 0, 0, 0, 5, 0, 32767), 1'b0, none);
    add_row(mk(mcc2d_pkg::CMD_LOAD_WGT, 0, 0, 0, 0, 0, 15, 32767), 1'b0, none);
    add_row(mk(mcc2d_pkg::CMD_LOAD_BIAS, 0, 63, 0, 0, 0, 0, 32767), 1'b0, none);
    fill_at = dir_rows.size();
    // extremes and saturation once the stores are full
    add_row(mk(mcc2d_pkg::CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 0), 1'b0, none);
    add_row(mk(mcc2d_pkg::CMD_LOAD_FEAT, 0, 0, 0, 0, 0, 0, 32767), 1'b0, none);
    add_row(mk(mcc2d_pkg::CMD_LOAD_WGT, 0, 0, 0, 0, 2, 2, 32767), 1'b0, none);
    add_row(mk(mcc2d_pkg::CMD_LOAD_BIAS, 0, 0, 0, 0, 0, 0, 32767), 1'b0, none);
    add_row(mk(mcc2d_pkg::CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 0), 1'b0, none);
    add_row(mk(mcc2d_pkg::CMD_LOAD_WGT, 0, 0, 0, 0, 2, 2, -32768), 1'b0, none);
    add_row(mk(mcc2d_pkg::CMD_LOAD_BIAS, 0, 0, 0, 0, 0, 0, -32768), 1'b0, none);
    add_row(mk(mcc2d_pkg::CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 0), 1'b0, none);
    add_row(mk(mcc2d_pkg::CMD_LOAD_WGT, N_IC - 1, 0, 0, 0, N_K - 1, N_K - 1, -32768), 1'b0,
            none);
    add_row(mk(mcc2d_pkg::CMD_LOAD_BIAS, 0, 0, 0, 0, 0, 0, 0), 1'b0, none);
    add_row(mk(mcc2d_pkg::CMD_COMPUTE, 0, 0, 1, 1, 0, 0, 0), 1'b0, none);
    add_row(mk(mcc2d_pkg::CMD_COMPUTE, 0, 0, N_H - 1, N_W - 1, 0, 0, 0), 1'b0, none);

    foreach (dir_rows[i]) begin
      mcc2d_pkg::out_word_t res;
      if (i == fill_at) fill_stores();
      word_q.push_back(dir_rows[i].w);
      if (conv_pixel(dir_rows[i].w, res))
        pixel_q.push_back(dir_rows[i].typed ? dir_rows[i].res : res);
    end
    repeat (N_RAND) rand_word();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    while (word_q.size() > 0) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
      while (burst > 0 && word_q.size() > 0) begin
        in_data <= word_q.pop_front();
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst--;
      end
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0 || word_q.size() == 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pixel_q.size() > 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (1000) @(posedge clk);

    if (errors == 0 && pixel_q.size() == 0) begin
      $display("[multichannel_conv2d_replicate_pad] OK");
    end else begin
      if (pixel_q.size() > 0) $display("%0d expected words never arrived", pixel_q.size());
      $display("[multichannel_conv2d_replicate_pad] ERROR");
    end
    $finish;
  end

endmodule
